[hdl/cha_pkg.sv]
package cha_pkg;

   localparam int SLOTS_PER_CHUNK    = 32;
   localparam int MAX_CHUNKS         = 8;
   localparam int KERNEL_HANDLE_BITS = 16;

   localparam int TABLE_SLOTS     = 256;
   localparam int HANDLE_BITS     = 8;
   localparam int KERNEL_OUT_BITS = 16;
   localparam int KERNEL_IN_BITS  = 16;
   localparam int RESERVED_SLOTS  = 3;

   // used marks are kept as rows of a fixed width, independent of the chunk size
   localparam int ROW_BITS     = 32;
   localparam int ROWS         = TABLE_SLOTS / ROW_BITS;
   localparam int ROW_IDX_BITS = $clog2(ROWS);
   localparam int BIT_IDX_BITS = $clog2(ROW_BITS);

   localparam int ACT_BITS = $clog2(MAX_CHUNKS + 1);
   localparam int LIM_BITS = ACT_BITS + $clog2(TABLE_SLOTS + 1);

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_SET   = 2'd2,
      CMD_GET   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic                   start;
      logic                   commit;
      cmd_type                cmd;
      logic [HANDLE_BITS-1:0] handle;
   } used_req_type;

   typedef struct packed {
      logic                   granted;
      logic [HANDLE_BITS-1:0] grant;
      logic                   in_range;
   } used_rsp_type;

   function automatic logic [ROW_BITS-1:0] row_reset(input logic [ROW_IDX_BITS-1:0] row);
      logic [ROW_BITS-1:0] val;
      val = '0;
      if (row == '0) begin
         val = ROW_BITS'((1 << RESERVED_SLOTS) - 1);
      end
      return val;
   endfunction

   function automatic logic [KERNEL_OUT_BITS-1:0] kmap_reset(input logic [HANDLE_BITS-1:0] h);
      logic [KERNEL_OUT_BITS-1:0] val;
      val = '0;
      if (int'(h) < RESERVED_SLOTS) begin
         val = KERNEL_OUT_BITS'(h);
      end
      return val;
   endfunction

endpackage

[hdl/cha_used_table.sv]
module cha_used_table (
   input  logic                  clock,
   input  logic                  reset,
   input  cha_pkg::used_req_type req,
   output cha_pkg::used_rsp_type rsp
);

   localparam int RB = cha_pkg::ROW_BITS;
   localparam int RI = cha_pkg::ROW_IDX_BITS;
   localparam int BI = cha_pkg::BIT_IDX_BITS;
   localparam int HB = cha_pkg::HANDLE_BITS;
   localparam int LB = cha_pkg::LIM_BITS;
   localparam int AB = cha_pkg::ACT_BITS;

   logic [RB-1:0] used_mem [cha_pkg::ROWS];

   logic [AB-1:0]             active_ff, active_in;
   logic [cha_pkg::ROWS-1:0]  full_ff, row_vld_ff;
   logic [RB-1:0]             rd_row_ff;
   logic                      rd_vld_ff;
   logic [RI-1:0]             row_sel_ff;
   logic                      cand_ff;
   cha_pkg::cmd_type          cmd_ff;
   logic [HB-1:0]             handle_ff;

   logic [LB-1:0] limit;
   logic          cand;
   logic [RI-1:0] cand_row;
   logic [RI-1:0] rd_addr;

   logic [RB-1:0] row_cur, beyond, masked;
   logic [BI-1:0] free_bit;
   logic          hit, can_grow, granted, in_range;
   logic [HB-1:0] grant;
   logic          wr_en;
   logic [RI-1:0] wr_row;
   logic [RB-1:0] wr_data;

   assign limit = LB'(active_ff) * LB'(cha_pkg::SLOTS_PER_CHUNK);

   // lowest row with room that starts below the active limit
   always_comb begin
      cand     = 1'b0;
      cand_row = '0;
      for (int r = cha_pkg::ROWS - 1; r >= 0; r--) begin
         if (!full_ff[r] && (LB'(r * RB) < limit)) begin
            cand     = 1'b1;
            cand_row = RI'(r);
         end
      end
   end

   assign rd_addr = (req.cmd == cha_pkg::CMD_ALLOC) ? cand_row : req.handle[HB-1 -: RI];

   always_comb begin
      row_cur = rd_vld_ff ? rd_row_ff : cha_pkg::row_reset(row_sel_ff);
      for (int b = 0; b < RB; b++) begin
         beyond[b] = (LB'({row_sel_ff, BI'(b)}) >= limit);
      end
      masked   = row_cur | beyond;
      free_bit = '0;
      for (int b = RB - 1; b >= 0; b--) begin
         if (!masked[b]) begin
            free_bit = BI'(b);
         end
      end
   end

   assign hit      = cand_ff && (masked != '1);
   assign can_grow = (active_ff < AB'(cha_pkg::MAX_CHUNKS)) &&
                     (limit < LB'(cha_pkg::TABLE_SLOTS));
   assign granted  = hit || can_grow;
   assign grant    = hit ? {row_sel_ff, free_bit} : limit[HB-1:0];
   assign in_range = LB'(handle_ff) < limit;

   // when growing, the row read (if any) is the one holding the new chunk's first slot
   always_comb begin
      wr_en   = 1'b0;
      wr_row  = handle_ff[HB-1 -: RI];
      wr_data = row_cur & ~(RB'(1) << handle_ff[BI-1:0]);
      if (cmd_ff == cha_pkg::CMD_ALLOC) begin
         wr_en   = req.commit && granted;
         wr_row  = grant[HB-1 -: RI];
         wr_data = (cand_ff ? row_cur : '0) | (RB'(1) << grant[BI-1:0]);
      end else if (cmd_ff == cha_pkg::CMD_FREE) begin
         wr_en = req.commit && in_range;
      end
   end

   assign active_in = (req.commit && (cmd_ff == cha_pkg::CMD_ALLOC) && !hit && can_grow) ?
                      active_ff + AB'(1) : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= AB'(1);
         full_ff    <= '0;
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         cand_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         if (req.start) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
            cand_ff   <= cand;
         end
         if (wr_en) begin
            row_vld_ff[wr_row] <= 1'b1;
            full_ff[wr_row]    <= &wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rd_row_ff  <= used_mem[rd_addr];
         row_sel_ff <= rd_addr;
         cmd_ff     <= req.cmd;
         handle_ff  <= req.handle;
      end
      if (wr_en) begin
         used_mem[wr_row] <= wr_data;
      end
   end

   assign rsp.granted  = granted;
   assign rsp.grant    = grant;
   assign rsp.in_range = in_range;

endmodule

[hdl/chunked_handle_allocator_top.sv]
// chunked handle allocator
// req channel carries one command item: allocate, free, set or get a kernel
// handle for a process handle. rsp channel returns exactly one item per
// command with the granted or echoed handle, the kernel handle read by get
// and a status (ok, table full, handle in an inactive chunk).
// on each item the accept cycle issues the reads of the used-mark row and
// the kernel map entry, and the execute state applies the search or update
// to the read data and writes it back; the reads of these two memories are
// registered, and one item is worked on at a time.
// the result sits in an output register, so a new item is taken while the
// previous result still waits; if the receiver stalls longer, the block holds
// the finished item in its execute state and takes nothing new.
// reset makes chunk 0 active with handles 0 to 2 in use and mapped to kernel
// handles 0 to 2; per-entry valid bits stand in for clearing the memories, so
// the block is ready at once.
module chunked_handle_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_handle,
   input  logic [15:0] req_kernel_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_handle_out,
   output logic [15:0] rsp_kernel_out,
   output logic [1:0]  rsp_status
);

   localparam int KB = cha_pkg::KERNEL_HANDLE_BITS;
   localparam int HB = cha_pkg::HANDLE_BITS;
   localparam int OB = cha_pkg::KERNEL_OUT_BITS;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [HB-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [OB-1:0]      rsp_kernel_ff, rsp_kernel_in;
   cha_pkg::status_type rsp_status_ff, rsp_status_in;

   cha_pkg::cmd_type cmd_ff;
   logic [HB-1:0]    handle_ff;
   logic [KB-1:0]    kv_ff;

   logic [KB-1:0] kmap_mem [cha_pkg::TABLE_SLOTS];
   logic [cha_pkg::TABLE_SLOTS-1:0] k_vld_ff;
   logic [KB-1:0] k_rd_ff;
   logic          k_rd_vld_ff;

   logic accept, commit, set_we;
   logic [31:0] kv_wide, k_rd_wide;

   cha_pkg::used_req_type used_req;
   cha_pkg::used_rsp_type used_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign used_req.start  = accept;
   assign used_req.commit = commit;
   assign used_req.cmd    = cha_pkg::cmd_type'(req_cmd);
   assign used_req.handle = req_handle;

   cha_used_table u_used (
      .clock (clock),
      .reset (reset),
      .req   (used_req),
      .rsp   (used_rsp)
   );

   assign kv_wide   = {16'b0, req_kernel_value};
   assign k_rd_wide = 32'(k_rd_ff);
   assign set_we    = commit && (cmd_ff == cha_pkg::CMD_SET) && used_rsp.in_range;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cha_pkg::cmd_type'(req_cmd);
         handle_ff <= req_handle;
         kv_ff     <= kv_wide[KB-1:0];
         k_rd_ff   <= kmap_mem[req_handle];
      end
      if (set_we) begin
         kmap_mem[handle_ff] <= kv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff    <= '0;
         k_rd_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            k_rd_vld_ff <= k_vld_ff[req_handle];
         end
         if (set_we) begin
            k_vld_ff[handle_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_kernel_in = rsp_kernel_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_handle_in = handle_ff;
               rsp_kernel_in = '0;
               rsp_status_in = cha_pkg::STATUS_OK;
               if (cmd_ff == cha_pkg::CMD_ALLOC) begin
                  if (used_rsp.granted) begin
                     rsp_handle_in = used_rsp.grant;
                  end else begin
                     rsp_handle_in = '0;
                     rsp_status_in = cha_pkg::STATUS_FULL;
                  end
               end else if (!used_rsp.in_range) begin
                  rsp_status_in = cha_pkg::STATUS_INVALID;
               end else if (cmd_ff == cha_pkg::CMD_GET) begin
                  rsp_kernel_in = k_rd_vld_ff ? k_rd_wide[OB-1:0] :
                                  cha_pkg::kmap_reset(handle_ff);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_kernel_ff <= rsp_kernel_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_kernel_out = rsp_kernel_ff;
   assign rsp_status     = rsp_status_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC) && !req_ready)
      else $error("accepted item did not move to execute");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("finished item not presented on rsp");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == cha_pkg::STATUS_FULL)) |->
         (rsp_handle_ff == '0) && (rsp_kernel_ff == '0))
      else $error("table full result carries a handle or kernel value");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == cha_pkg::STATUS_INVALID)) |->
         (rsp_kernel_ff == '0))
      else $error("invalid handle result carries a kernel value");

endmodule
